FILE: hdl/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg
// Shared types and constants for the staggered enable sequencer.
// ----------------------------------------------------------------------------
package ses_pkg;

  // Channel bank size and field widths
  localparam int unsigned CHANNELS = 18;
  localparam int unsigned MASK_W   = 18;
  localparam int unsigned DELAY_W  = 8;
  localparam int unsigned OP_W     = 2;

  // Reset value of the tick delay register
  localparam logic [DELAY_W-1:0] TICK_DELAY_RST = DELAY_W'(10);

  // Channels that can actually be switched on
  localparam logic [MASK_W-1:0] CHAN_BITS = MASK_W'((64'd1 << CHANNELS) - 64'd1);

  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [DELAY_W-1:0] delay_t;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 2'd0,
    OP_SET_INTENT  = 2'd1,
    OP_SET_BLOCKED = 2'd2,
    OP_OFF         = 2'd3
  } op_e;

endpackage

FILE: hdl/ses_if.sv
// ----------------------------------------------------------------------------
// ses_in_if / ses_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ses_in_if import ses_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [MASK_W-1:0]   mask_value;

  modport source (output valid, output operation, output mask_value, input ready);
  modport sink   (input valid, input operation, input mask_value, output ready);
endinterface

interface ses_out_if import ses_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MASK_W-1:0]   enable_mask;
  logic [MASK_W-1:0]   goal_mask;
  logic                sequence_done;

  modport source (output valid, output enable_mask, output goal_mask,
                  output sequence_done, input ready);
  modport sink   (input valid, input enable_mask, input goal_mask,
                  input sequence_done, output ready);
endinterface

FILE: hdl/staggered_enable_sequencer.sv
// ----------------------------------------------------------------------------
// staggered_enable_sequencer
// Power enable sequencer that switches on targeted channels one at a time.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item holding the enable
// mask, the effective target mask and the done flag as they stand after the
// operation. Items pass through an input register and a result register with
// the state update in between: an accepted item is captured in the input
// register, and its result is written to the result register when it advances;
// one item can be accepted every cycle and the only throttle is the output
// side's ready. The tick delay is written through cfg_we_i/cfg_wdata_i and
// should only change while no items are in flight.
module staggered_enable_sequencer
  import ses_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DELAY_W-1:0] cfg_wdata_i,
  ses_in_if.sink             in_i,
  ses_out_if.source          out_o
);

  // Configuration
  delay_t tick_delay_q;

  // Input register
  logic              in_vld_q;
  op_e               op_q;
  mask_t             mval_q;

  // Sequencer state
  mask_t  intent_q, intent_d;
  mask_t  blocked_q, blocked_d;
  mask_t  enabled_q, enabled_d;
  logic   done_q, done_d;
  delay_t count_q, count_d;

  // Result register
  logic   out_vld_q;
  mask_t  res_en_q, res_tgt_q;
  logic   res_done_q;

  logic   advance;
  mask_t  target_cur, pending, lowest, target_new;

  // Pipeline control
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_delay_q <= TICK_DELAY_RST;
    end else if (cfg_we_i) begin
      tick_delay_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= op_e'(in_i.operation);
      mval_q <= in_i.mask_value;
    end
  end

  // Lowest targeted channel that is still off
  assign target_cur = intent_q & ~blocked_q;
  assign pending    = target_cur & ~enabled_q & CHAN_BITS;
  assign lowest     = pending & (~pending + MASK_W'(1));

  // Next state for the item in the input register
  always_comb begin
    intent_d  = intent_q;
    blocked_d = blocked_q;
    enabled_d = enabled_q;
    done_d    = done_q;
    count_d   = count_q;
    case (op_q)
      OP_TICK: begin
        if (done_q) begin
          count_d = '0;
        end else if (count_q == tick_delay_q && pending != '0) begin
          enabled_d = enabled_q | lowest;
          count_d   = '0;
        end else begin
          if (count_q == tick_delay_q) begin
            done_d = 1'b1;
          end
          count_d = count_q + delay_t'(1);
        end
      end
      OP_SET_INTENT: begin
        intent_d  = mval_q;
        enabled_d = enabled_q & mval_q & ~blocked_q & CHAN_BITS;
        done_d    = 1'b0;
      end
      OP_SET_BLOCKED: begin
        blocked_d = mval_q;
        enabled_d = enabled_q & intent_q & ~mval_q & CHAN_BITS;
        done_d    = 1'b0;
      end
      OP_OFF: begin
        enabled_d = enabled_q & ~mval_q;
      end
      default: begin
        enabled_d = enabled_q;
      end
    endcase
  end

  assign target_new = intent_d & ~blocked_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intent_q  <= '0;
      blocked_q <= '0;
      enabled_q <= '0;
      done_q    <= 1'b0;
      count_q   <= '0;
    end else if (advance) begin
      intent_q  <= intent_d;
      blocked_q <= blocked_d;
      enabled_q <= enabled_d;
      done_q    <= done_d;
      count_q   <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_en_q   <= enabled_d;
      res_tgt_q  <= target_new;
      res_done_q <= done_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.enable_mask   = res_en_q;
  assign out_o.goal_mask     = res_tgt_q;
  assign out_o.sequence_done = res_done_q;

endmodule

FILE: hdl/ses_checker.sv
// ----------------------------------------------------------------------------
// ses_checker
// Port-level checks for the staggered enable sequencer, bound to the top.
// ----------------------------------------------------------------------------
module ses_checker
  import ses_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [MASK_W-1:0] enable_mask_i,
  input logic [MASK_W-1:0] goal_mask_i,
  input logic        sequence_done_i
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(enable_mask_i)
      && $stable(goal_mask_i) && $stable(sequence_done_i))
    else $error("result changed while stalled");

  // Only targeted channels are ever on
  a_en_in_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (enable_mask_i & ~goal_mask_i) == '0)
    else $error("enabled channel outside target");

  // Channels beyond the bank never switch on
  a_en_in_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (enable_mask_i & ~CHAN_BITS) == '0)
    else $error("enable beyond channel count");

  // No result right out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid after reset");

endmodule

bind staggered_enable_sequencer ses_checker u_ses_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .enable_mask_i   (out_o.enable_mask),
  .goal_mask_i     (out_o.goal_mask),
  .sequence_done_i (out_o.sequence_done)
);
